// ----- src/qr_codeword_deinterleaver_unit_defines.svh -----
// ----------------------------------------------------------------------------
// QR codeword de-interleaver assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef QR_CODEWORD_DEINTERLEAVER_UNIT_DEFINES_SVH
`define QR_CODEWORD_DEINTERLEAVER_UNIT_DEFINES_SVH

// invariant checked on every edge out of reset
`define QRDI_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define QRDI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/qrdi_pkg.sv -----
// ----------------------------------------------------------------------------
// QR de-interleaver package
// Widths, limits, register indexes, controller states and shared structs.
// ----------------------------------------------------------------------------
package qrdi_pkg;

  localparam int MAX_BLOCKS    = 128;
  localparam int MAX_CODEWORDS = 4096;
  localparam int POS_LIMIT     = (MAX_CODEWORDS < 4096) ? MAX_CODEWORDS : 4096;

  localparam int CW_W   = 8;   // codeword byte
  localparam int POS_W  = 12;  // output position
  localparam int REG_W  = 8;   // config register width
  localparam int CNT_W  = 16;  // symbol totals, up to 128*255
  localparam int IDX_W  = 3;   // config register index

  typedef enum logic [IDX_W-1:0] {
    REG_G1_BLOCKS = 3'd0,
    REG_G1_DATA   = 3'd1,
    REG_G1_TOTAL  = 3'd2,
    REG_G2_BLOCKS = 3'd3,
    REG_G2_DATA   = 3'd4,
    REG_G2_TOTAL  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_LOAD1,
    ST_LOAD2,
    ST_LOAD3,
    ST_STEP,
    ST_CALC
  } ctrl_state_t;

  typedef struct packed {
    logic [REG_W-1:0] g1_blocks;
    logic [REG_W-1:0] g1_data;
    logic [REG_W-1:0] g1_total;
    logic [REG_W-1:0] g2_blocks;
    logic [REG_W-1:0] g2_data;
    logic [REG_W-1:0] g2_total;
  } cfg_regs_t;

  typedef struct packed {
    logic cap;    // capture input byte
    logic step;   // pick next block slot, stage position operands
    logic load0;  // latch layout, group 1 data size
    logic load1;  // data total
    logic load2;  // group 2 ECC base
    logic load3;  // symbol total
    logic calc;   // finish position, load result register
  } dp_cmd_t;

endpackage

// ----- src/qrdi_cfg.sv -----
// ----------------------------------------------------------------------------
// QR de-interleaver configuration registers
// Write decode of the six layout registers.
// ----------------------------------------------------------------------------
module qrdi_cfg
  import qrdi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output cfg_regs_t        regs
);

  cfg_regs_t regs_r;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.g1_blocks <= 8'd1;
      regs_r.g1_data   <= 8'd1;
      regs_r.g1_total  <= 8'd1;
      regs_r.g2_blocks <= 8'd0;
      regs_r.g2_data   <= 8'd1;
      regs_r.g2_total  <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_G1_BLOCKS: regs_r.g1_blocks <= cfg_data;
        REG_G1_DATA:   regs_r.g1_data   <= cfg_data;
        REG_G1_TOTAL:  regs_r.g1_total  <= cfg_data;
        REG_G2_BLOCKS: regs_r.g2_blocks <= cfg_data;
        REG_G2_DATA:   regs_r.g2_data   <= cfg_data;
        REG_G2_TOTAL:  regs_r.g2_total  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/qrdi_dp.sv -----
// ----------------------------------------------------------------------------
// QR de-interleaver datapath
// Latched layout, round/block pointer, shared 8x8 multiplier, result register.
// ----------------------------------------------------------------------------
`include "qr_codeword_deinterleaver_unit_defines.svh"

module qrdi_dp
  import qrdi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  cfg_regs_t        cfg,
  input  logic [CW_W-1:0]  in_codeword,
  output logic [CW_W-1:0]  codeword_out,
  output logic [POS_W-1:0] position,
  output logic             is_ecc,
  output logic             last,
  output logic             overflow
);

  // latched layout
  logic [REG_W-1:0] g1_r, g2_r, nb_r, d1_r, d2_r, e1_r, e2_r;
  logic [CNT_W-1:0] gd1_r, dt_r, eb2_r, sym_r;
  // walk state: round = codewords already taken by each visited block
  logic [CNT_W-1:0] count_r;
  logic             ecc_r, fresh_r;
  logic [REG_W-1:0] r_r, b_r;
  // staged item
  logic [CW_W-1:0]  cw_r;
  logic [REG_W-1:0] ma_r, mb_r;
  logic [CNT_W-1:0] off_r;
  logic             pecc_r, plast_r, povf_r;
  // result register
  logic [CW_W-1:0]  cwo_r;
  logic [POS_W-1:0] pos_r;
  logic             ecco_r, lasto_r, ovfo_r;

  // ---- layout clamps from the live registers
  logic [REG_W-1:0] g1c, room, g2c, e1c, e2c;
  always_comb begin
    g1c  = (cfg.g1_blocks < REG_W'(MAX_BLOCKS)) ? cfg.g1_blocks : REG_W'(MAX_BLOCKS);
    room = REG_W'(MAX_BLOCKS) - g1c;
    g2c  = (cfg.g2_blocks < room) ? cfg.g2_blocks : room;
    e1c  = (cfg.g1_total > cfg.g1_data) ? (cfg.g1_total - cfg.g1_data) : '0;
    e2c  = (cfg.g2_total > cfg.g2_data) ? (cfg.g2_total - cfg.g2_data) : '0;
  end

  // ---- next block slot
  logic             ovf_c, sw_c, eph, frs;
  logic [REG_W-1:0] s1, s2, rs, bs, idx_c, sz_c;
  logic [REG_W:0]   bn9, c2_9, rn9;
  logic             same_g1, same_g2, nr_g1, in_g1;
  logic [CNT_W-1:0] base_c, off_c;

  always_comb begin
    ovf_c   = (count_r >= sym_r) || (nb_r == '0);
    sw_c    = !ecc_r && (count_r >= dt_r);
    eph     = ecc_r | sw_c;
    frs     = fresh_r | sw_c;
    s1      = eph ? e1_r : d1_r;
    s2      = eph ? e2_r : d2_r;
    bn9     = {1'b0, b_r} + 9'd1;
    c2_9    = (bn9 > {1'b0, g1_r}) ? bn9 : {1'b0, g1_r};
    rn9     = frs ? '0 : ({1'b0, r_r} + 9'd1);
    same_g1 = !frs && (bn9 < {1'b0, g1_r}) && (s1 > r_r);
    same_g2 = !frs && (c2_9 < {1'b0, nb_r}) && (s2 > r_r);
    nr_g1   = (g1_r != '0) && ({1'b0, s1} > rn9);
    if (same_g1) begin
      rs = r_r;
      bs = bn9[REG_W-1:0];
    end else if (same_g2) begin
      rs = r_r;
      bs = c2_9[REG_W-1:0];
    end else if (nr_g1) begin
      rs = rn9[REG_W-1:0];
      bs = '0;
    end else begin
      rs = rn9[REG_W-1:0];
      bs = g1_r;
    end
    in_g1 = bs < g1_r;
    idx_c = in_g1 ? bs : (bs - g1_r);
    sz_c  = in_g1 ? s1 : s2;
    if (eph) base_c = in_g1 ? dt_r : eb2_r;
    else     base_c = in_g1 ? '0 : gd1_r;
    off_c = base_c + {{(CNT_W-REG_W){1'b0}}, rs};
  end

  // ---- shared multiply-add
  logic [REG_W-1:0]   mul_a, mul_b;
  logic [CNT_W-1:0]   add_c;
  logic [2*REG_W-1:0] prod;
  logic [CNT_W:0]     sum;
  logic               pos_ovf;

  always_comb begin
    if (cmd.load0) begin
      mul_a = g1c;  mul_b = cfg.g1_data; add_c = '0;
    end else if (cmd.load1) begin
      mul_a = g2_r; mul_b = d2_r;        add_c = gd1_r;
    end else if (cmd.load2) begin
      mul_a = g1_r; mul_b = e1_r;        add_c = dt_r;
    end else if (cmd.load3) begin
      mul_a = g2_r; mul_b = e2_r;        add_c = eb2_r;
    end else begin
      mul_a = ma_r; mul_b = mb_r;        add_c = off_r;
    end
    prod    = mul_a * mul_b;
    sum     = {1'b0, add_c} + {1'b0, prod};
    pos_ovf = povf_r || (sum >= (CNT_W+1)'(POS_LIMIT));
  end

  // ---- layout and walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_r    <= 8'd1;
      g2_r    <= '0;
      nb_r    <= 8'd1;
      d1_r    <= 8'd1;
      d2_r    <= 8'd1;
      e1_r    <= '0;
      e2_r    <= '0;
      gd1_r   <= 16'd1;
      dt_r    <= 16'd1;
      eb2_r   <= 16'd1;
      sym_r   <= 16'd1;
      count_r <= '0;
      ecc_r   <= 1'b0;
      fresh_r <= 1'b1;
      r_r     <= '0;
      b_r     <= '0;
    end else begin
      if (cmd.load0) begin
        g1_r    <= g1c;
        g2_r    <= g2c;
        nb_r    <= g1c + g2c;
        d1_r    <= cfg.g1_data;
        d2_r    <= cfg.g2_data;
        e1_r    <= e1c;
        e2_r    <= e2c;
        gd1_r   <= sum[CNT_W-1:0];
        count_r <= '0;
        ecc_r   <= 1'b0;
        fresh_r <= 1'b1;
      end
      if (cmd.load1) dt_r  <= sum[CNT_W-1:0];
      if (cmd.load2) eb2_r <= sum[CNT_W-1:0];
      if (cmd.load3) sym_r <= sum[CNT_W-1:0];
      if (cmd.step && !ovf_c) begin
        count_r <= count_r + 16'd1;
        ecc_r   <= eph;
        fresh_r <= 1'b0;
        r_r     <= rs;
        b_r     <= bs;
      end
    end
  end

  // ---- staged operands and result payload
  always_ff @(posedge clk) begin
    if (cmd.cap) cw_r <= in_codeword;
    if (cmd.step) begin
      ma_r    <= ovf_c ? '0 : idx_c;
      mb_r    <= ovf_c ? '0 : sz_c;
      off_r   <= ovf_c ? '0 : off_c;
      pecc_r  <= !ovf_c && eph;
      plast_r <= !ovf_c && ((count_r + 16'd1) == sym_r);
      povf_r  <= ovf_c;
    end
    if (cmd.calc) begin
      cwo_r   <= cw_r;
      pos_r   <= pos_ovf ? '0 : sum[POS_W-1:0];
      ecco_r  <= pecc_r;
      lasto_r <= plast_r;
      ovfo_r  <= pos_ovf;
    end
  end

  assign codeword_out = cwo_r;
  assign position     = pos_r;
  assign is_ecc       = ecco_r;
  assign last         = lasto_r;
  assign overflow     = ovfo_r;

  `QRDI_ASSERT_ALWAYS(a_count_bound, count_r <= sym_r, "codeword count passed symbol total")
  `QRDI_ASSERT_IMPL(a_ecc_after_data, ecc_r, count_r >= dt_r, "ECC phase before data done")

endmodule

// ----- src/qrdi_ctrl.sv -----
// ----------------------------------------------------------------------------
// QR de-interleaver controller
// Sequences layout load, slot selection and result hand-off.
// ----------------------------------------------------------------------------
module qrdi_ctrl
  import qrdi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_first,
  output logic    in_tready,
  input  logic    out_tready,
  output logic    out_tvalid,
  output dp_cmd_t cmd
);

  ctrl_state_t st_r, st_nxt;
  logic        ovld_r, ovld_nxt;
  logic        acc;

  assign acc = in_tvalid && in_tready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (acc) st_nxt = in_first ? ST_LOAD0 : ST_CALC;
      ST_LOAD0: st_nxt = ST_LOAD1;
      ST_LOAD1: st_nxt = ST_LOAD2;
      ST_LOAD2: st_nxt = ST_LOAD3;
      ST_LOAD3: st_nxt = ST_STEP;
      ST_STEP:  st_nxt = ST_CALC;
      ST_CALC:  if (!ovld_r || out_tready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // ready is high throughout IDLE, so valid alone marks the accept there
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (st_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
        cmd.step  = in_tvalid && !in_first;
      end
      ST_LOAD0: cmd.load0 = 1'b1;
      ST_LOAD1: cmd.load1 = 1'b1;
      ST_LOAD2: cmd.load2 = 1'b1;
      ST_LOAD3: cmd.load3 = 1'b1;
      ST_STEP:  cmd.step  = 1'b1;
      ST_CALC:  cmd.calc  = !ovld_r || out_tready;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.calc)        ovld_nxt = 1'b1;
    else if (out_tready) ovld_nxt = 1'b0;
    else                 ovld_nxt = ovld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;

endmodule

// ----- src/qr_codeword_deinterleaver_unit.sv -----
// ----------------------------------------------------------------------------
// QR codeword de-interleaver
// Tags each codeword of a QR symbol with its index in block order.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake               Payload
// in_      in   in_tvalid/in_tready     tdata: codeword; tuser: first
// out_     out  out_tvalid/out_tready   tdata: codeword_out, position;
//                                       tuser: is_ecc, overflow; tlast: last
// cfg_     in   cfg_valid/cfg_ready     cfg_index, cfg_data (cfg_ready tied high)
//
// Plain codeword: accept + slot pick, then one pass through the shared 8x8
//   multiply-add; the multiplier is the only shared unit.
// Codeword with first set: accept, four loads of layout totals on the same
//   multiplier, then the slot pick and the multiply-add pass.
// rst_n is synchronous; reset leaves a one-block, one-codeword layout loaded.
// The result register holds while out_tready is low; a new codeword can still
//   be taken meanwhile and then waits in its last cycle for the register.
//
// Block order is computed in closed form: within a phase, blocks of each group
// are equal, so the round-robin walk is a (round, block) pointer and the
// position is base + block_in_group * size + round.
// ----------------------------------------------------------------------------
`include "qr_codeword_deinterleaver_unit_defines.svh"

module qr_codeword_deinterleaver_unit
  import qrdi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] codeword
  input  logic             in_tuser,   // [0] first
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,  // [7:0] codeword_out, [19:8] position, rest zero
  output logic [1:0]       out_tuser,  // [0] is_ecc, [1] overflow
  output logic             out_tlast,  // last codeword of the symbol
  // configuration writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  cfg_regs_t        regs;
  dp_cmd_t          cmd;
  logic [CW_W-1:0]  cw_out;
  logic [POS_W-1:0] pos;
  logic             ecc, lst, ovf;

  qrdi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  qrdi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_first   (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  qrdi_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg          (regs),
    .in_codeword  (in_tdata),
    .codeword_out (cw_out),
    .position     (pos),
    .is_ecc       (ecc),
    .last         (lst),
    .overflow     (ovf)
  );

  assign out_tdata = {4'b0000, pos, cw_out};
  assign out_tuser = {ovf, ecc};
  assign out_tlast = lst;

  // flagged codewords never carry a position
  `QRDI_ASSERT_IMPL(a_ovf_pos_zero, out_tvalid && out_tuser[1], out_tdata[19:8] == 12'd0, "overflow with nonzero position")

endmodule
